/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pim_pkg.sv */
// Package for the priority inheritance mutex: sizes, codes, entry and command types.
// No dependencies.
package pim_pkg;

	localparam int MAX_WAITERS = 16;
	localparam int ID_BITS     = 8;
	localparam int PRIO_BITS   = 8;
	localparam int CNT_W       = $clog2(MAX_WAITERS + 1);
	localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

	localparam logic [1:0] MODE_LOCK   = 2'd0;
	localparam logic [1:0] MODE_UNLOCK = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_QUEUED    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT   = 3'd2;
	localparam logic [2:0] ST_NOT_OWNER = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture; // latch the request word
		logic commit;  // apply the request, load the result word
	} cmd_t;

endpackage

/* rtl/pim_ctrl.sv */
// Controller for the priority inheritance mutex: request sequencing and result handshake.
// Depends on pim_pkg.
module pim_ctrl
	import pim_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	// wait in EXEC until the result slot is free or being drained
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/pim_dp.sv */
// Datapath for the priority inheritance mutex: owner registers, sorted wait queue,
// result registers. Depends on pim_pkg.
module pim_dp
	import pim_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [1:0]           mode,
	input  logic [ID_BITS-1:0]   task_id,
	input  logic [PRIO_BITS-1:0] task_priority,
	input  logic                 no_wait,
	output logic [2:0]           status,
	output logic                 owner_valid,
	output logic [ID_BITS-1:0]   owner_task,
	output logic [PRIO_BITS-1:0] owner_effective_priority,
	output logic                 handed_over,
	output logic [CNT_W-1:0]     waiter_count
);

	// request word
	logic [1:0]           mode_q;
	logic [ID_BITS-1:0]   id_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 nw_q;

	// mutex state
	logic                 held_q;
	logic [ID_BITS-1:0]   hid_q;
	logic [PRIO_BITS-1:0] hbase_q;
	logic [PRIO_BITS-1:0] heff_q;
	logic [CNT_W-1:0]     len_q;
	entry_t               q_q [MAX_WAITERS];

	// next state
	logic                 held_n;
	logic [ID_BITS-1:0]   hid_n;
	logic [PRIO_BITS-1:0] hbase_n;
	logic [PRIO_BITS-1:0] heff_n;
	logic [CNT_W-1:0]     len_n;
	entry_t               q_n [MAX_WAITERS];
	logic [2:0]           st_n;
	logic                 hand_n;

	logic [MAX_WAITERS-1:0] ahead;
	logic                 hit;
	logic [IDX_W-1:0]     midx;
	logic [IDX_W-1:0]     ridx;
	logic                 do_ins;
	logic                 do_rem;

	// entries that stay ahead of a new waiter; a prefix, since the queue is sorted
	always_comb begin
		for (int k = 0; k < MAX_WAITERS; k++)
			ahead[k] = (CNT_W'(k) < len_q) && (q_q[k].prio <= prio_q);
	end

	// first queued entry with matching id
	always_comb begin
		hit  = 1'b0;
		midx = '0;
		for (int k = MAX_WAITERS - 1; k >= 0; k--) begin
			if ((CNT_W'(k) < len_q) && (q_q[k].id == id_q)) begin
				hit  = 1'b1;
				midx = IDX_W'(k);
			end
		end
	end

	always_comb begin
		held_n  = held_q;
		hid_n   = hid_q;
		hbase_n = hbase_q;
		heff_n  = heff_q;
		len_n   = len_q;
		st_n    = ST_OK;
		hand_n  = 1'b0;
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		ridx    = '0;
		case (mode_q)
			MODE_LOCK: begin
				if (!held_q) begin
					held_n  = 1'b1;
					hid_n   = id_q;
					hbase_n = prio_q;
					heff_n  = prio_q;
				end else if (nw_q) begin
					st_n = ST_TIMEOUT;
				end else if (len_q == CNT_W'(MAX_WAITERS)) begin
					st_n = ST_FULL;
				end else begin
					st_n   = ST_QUEUED;
					do_ins = 1'b1;
					len_n  = len_q + CNT_W'(1);
					if (heff_q > prio_q) heff_n = prio_q;
				end
			end
			MODE_UNLOCK: begin
				if (!held_q || (hid_q != id_q)) begin
					st_n = ST_NOT_OWNER;
				end else if (len_q != '0) begin
					hid_n   = q_q[0].id;
					hbase_n = q_q[0].prio;
					heff_n  = q_q[0].prio;
					do_rem  = 1'b1;
					len_n   = len_q - CNT_W'(1);
					hand_n  = 1'b1;
				end else begin
					held_n = 1'b0;
					heff_n = hbase_q;
				end
			end
			MODE_CANCEL: begin
				if (hit) begin
					st_n   = ST_TIMEOUT;
					do_rem = 1'b1;
					ridx   = midx;
					len_n  = len_q - CNT_W'(1);
				end
			end
			default: st_n = ST_OK;
		endcase
	end

	// queue shift network: each slot takes itself, its lower or upper neighbor, or the new entry
	always_comb begin
		for (int k = 0; k < MAX_WAITERS; k++) begin
			q_n[k] = q_q[k];
			if (do_ins) begin
				// first slot not ahead takes the new entry, the rest move up by one
				if (!ahead[k]) begin
					if ((k == 0) || ahead[(k > 0) ? k - 1 : 0])
						q_n[k] = '{id: id_q, prio: prio_q};
					else
						q_n[k] = q_q[(k > 0) ? k - 1 : 0];
				end
			end else if (do_rem) begin
				if ((IDX_W'(k) >= ridx) && (k + 1 < MAX_WAITERS))
					q_n[k] = q_q[(k + 1 < MAX_WAITERS) ? k + 1 : k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			hid_q   <= '0;
			hbase_q <= '0;
			heff_q  <= '0;
			len_q   <= '0;
		end else if (cmd.commit) begin
			held_q  <= held_n;
			hid_q   <= hid_n;
			hbase_q <= hbase_n;
			heff_q  <= heff_n;
			len_q   <= len_n;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			id_q   <= task_id;
			prio_q <= task_priority;
			nw_q   <= no_wait;
		end
		if (cmd.commit) begin
			for (int k = 0; k < MAX_WAITERS; k++)
				q_q[k] <= q_n[k];
			status                   <= st_n;
			owner_valid              <= held_n;
			owner_task               <= held_n ? hid_n : '0;
			owner_effective_priority <= held_n ? heff_n : '0;
			handed_over              <= hand_n;
			waiter_count             <= len_n;
		end
	end

endmodule

/* rtl/priority_inheritance_mutex.sv */
// Priority inheritance mutex, top level. Depends on pim_pkg, pim_ctrl, pim_dp and
// assert_macros.svh.
//
// One request word (lock, unlock or cancel) is taken when in_valid and in_ready are
// both high; exactly one result word follows on the out channel. Each request is
// latched, then applied in the EXEC state, in which the whole sorted wait queue is
// updated in place by a per-slot shift network (insert behind equal priorities,
// removal of the head or of the first matching id) together with the owner
// registers. The next request is taken in the cycle after that, even while the
// previous result word still waits; the update stalls only if a second result would
// overwrite one not yet taken. The queue holds up to 16 waiters, the most urgent
// (lowest number) first. A waiter more urgent than the owner raises the owner's
// effective priority; an owner unlock restores it and passes the mutex to the queue
// head (handed_over = 1). When the mutex is free, owner_task and
// owner_effective_priority read zero. No clearing pass follows reset.
`include "assert_macros.svh"

module priority_inheritance_mutex
	import pim_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] task_id,
	input  logic [7:0] task_priority,
	input  logic       no_wait,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       owner_valid,
	output logic [7:0] owner_task,
	output logic [7:0] owner_effective_priority,
	output logic       handed_over,
	output logic [4:0] waiter_count
);

	cmd_t cmd;

	pim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pim_dp u_dp (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.cmd                      (cmd),
		.mode                     (mode),
		.task_id                  (task_id),
		.task_priority            (task_priority),
		.no_wait                  (no_wait),
		.status                   (status),
		.owner_valid              (owner_valid),
		.owner_task               (owner_task),
		.owner_effective_priority (owner_effective_priority),
		.handed_over              (handed_over),
		.waiter_count             (waiter_count)
	);

	// a handover always leaves the mutex held with status ok
	`ASSERT_IMPL(a_handover_held, out_valid && handed_over, owner_valid && (status == ST_OK), "handover without owner")
	// free mutex reports zero owner fields
	`ASSERT_IMPL(a_free_zero, out_valid && !owner_valid, (owner_task == '0) && (owner_effective_priority == '0), "free mutex shows owner")
	// a queued lock implies a held mutex and a nonempty queue
	`ASSERT_IMPL(a_queued_held, out_valid && (status == ST_QUEUED), owner_valid && (waiter_count != '0), "queued on free mutex")
	// queue never exceeds its depth
	`ASSERT_CLK(a_len_bound, !out_valid || (waiter_count <= 5'(MAX_WAITERS)), "waiter count over depth")
	// an accepted request blocks the input for the next cycle
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready while busy")

endmodule
